@@ src/tsp_pkg.sv @@
// Shared types and constants of the touch slider position core.
package tsp_pkg;

    localparam int DATA_W    = 16;
    localparam int IDX_W     = 4;
    localparam int CMD_W     = 1;
    localparam int PADCNT_W  = 5;
    localparam int CFG_IDX_W = 8;
    localparam int NUM_W     = 29;
    localparam int DIV_CNT_W = 5;

    localparam logic [CMD_W-1:0] CMD_MEASURE   = 1'b0;
    localparam logic [CMD_W-1:0] CMD_CALIBRATE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_PADS  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 8'd1;

    localparam logic [PADCNT_W-1:0] RESET_NUM_PADS  = 5'd10;
    localparam logic [DATA_W-1:0]   RESET_THRESHOLD = 16'd50;

    localparam logic [16:0] FULL_RANGE = 17'h10000;
    localparam logic [12:0] RANGE_EXT  = 13'd6048;

    typedef struct packed {
        logic                start;
        logic [NUM_W-1:0]    dividend;
        logic [DATA_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [NUM_W-1:0]    quotient;
    } t_div_rsp;

endpackage

@@ src/tsp_sample_if.sv @@
// Sample request channel: valid/ready with command, pad index and raw count.
interface tsp_sample_if;
    logic                              valid;
    logic                              ready;
    logic [tsp_pkg::CMD_W-1:0]         cmd;
    logic [tsp_pkg::IDX_W-1:0]         pad_index;
    logic [tsp_pkg::DATA_W-1:0]        raw_value;

    modport source (output valid, output cmd, output pad_index, output raw_value,
                    input ready);
    modport sink   (input valid, input cmd, input pad_index, input raw_value,
                    output ready);
endinterface

@@ src/tsp_result_if.sv @@
// Result request channel: valid/ready with touch flag and slider position.
interface tsp_result_if;
    logic                              valid;
    logic                              ready;
    logic                              touched;
    logic [tsp_pkg::DATA_W-1:0]        position;

    modport source (output valid, output touched, output position, input ready);
    modport sink   (input valid, input touched, input position, output ready);
endinterface

@@ src/tsp_cfg_if.sv @@
// Configuration write channel: valid/ready with register index and data.
interface tsp_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [tsp_pkg::CFG_IDX_W-1:0]     index;
    logic [tsp_pkg::DATA_W-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/tsp_div.sv @@
// Restoring serial divider, one quotient bit per cycle.
module tsp_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tsp_pkg::t_div_req i_req,
    output tsp_pkg::t_div_rsp o_rsp
);
    localparam int NW = tsp_pkg::NUM_W;
    localparam int DW = tsp_pkg::DATA_W;

    logic                          r_busy;
    logic                          r_done;
    logic [tsp_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [DW-1:0]                 r_rem;
    logic [NW-1:0]                 r_q;
    logic [DW-1:0]                 r_dvs;

    logic [DW:0] rem_sh;
    logic [DW:0] rem_sub;
    logic        ge;

    assign rem_sh  = {r_rem, r_q[NW-1]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};
    assign ge      = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= tsp_pkg::DIV_CNT_W'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == tsp_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_q   <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            r_q   <= {r_q[NW-2:0], ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

endmodule

@@ src/touch_slider_position_core.sv @@
// Touch slider position core: per-pad ambient/excess store and frame-end position search.
//
// Usage:
//   i_sample  : sample requests (cmd, pad_index, raw_value). A calibrate request stores
//               raw_value as the pad's ambient level; a measure request stores the excess
//               over ambient, floored at zero. Pads at or past MAX_PADS are dropped.
//   i_cfg     : register writes, always ready. Index 0 = pad total, 1 = touch threshold.
//   o_result  : one result (touched, position) per measure request on the last pad
//               of the frame (pad total - 1, total clamped to 2..MAX_PADS).
// Operation:
//   calibrate request: ambient write only; measure request that does not end a frame:
//   excess write in ST_EXC. Frame-end request: a pad scan through the excess memory
//   (one read per cycle), then up to two 29-step passes through the serial divider
//   (range per pad, then the neighbor ratio unless pinned or both neighbors are zero).
//   One request is worked on at a time; i_sample.ready is high only when idle.
// Reset: configuration returns to 10 pads and threshold 50, all ambient and
//   excess entries read as zero, no result pending.
// Stall: a finished result waits in the output register while new requests are taken;
//   the next frame-end result waits in its last step until that register is free.
module touch_slider_position_core #(
    parameter int MAX_PADS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tsp_sample_if.sink         i_sample,
    tsp_cfg_if.sink            i_cfg,
    tsp_result_if.source       o_result
);
    localparam int AW = (MAX_PADS > 1) ? $clog2(MAX_PADS) : 1;
    localparam int CW = $clog2(MAX_PADS + 1);
    localparam int DW = tsp_pkg::DATA_W;
    localparam int NW = tsp_pkg::NUM_W;
    localparam int PW = AW + DW;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_EXC   = 4'd1;
    localparam logic [3:0] ST_SCAN  = 4'd2;
    localparam logic [3:0] ST_NBR_A = 4'd3;
    localparam logic [3:0] ST_NBR_B = 4'd4;
    localparam logic [3:0] ST_NBR_C = 4'd5;
    localparam logic [3:0] ST_DIV_R = 4'd6;
    localparam logic [3:0] ST_MUL   = 4'd7;
    localparam logic [3:0] ST_DIV_S = 4'd8;
    localparam logic [3:0] ST_DIV_O = 4'd9;
    localparam logic [3:0] ST_POS   = 4'd10;
    localparam logic [3:0] ST_DONE  = 4'd11;

    logic [3:0]                   r_state;
    logic [3:0]                   n_state;
    logic [tsp_pkg::PADCNT_W-1:0] r_num_pads;
    logic [DW-1:0]                r_threshold;

    // ambient and excess stores
    logic [DW-1:0]       r_amb_mem [MAX_PADS];
    logic [DW-1:0]       r_exc_mem [MAX_PADS];
    logic [MAX_PADS-1:0] r_amb_vld;
    logic [MAX_PADS-1:0] r_exc_vld;
    logic [DW-1:0]       r_amb_q;
    logic                r_amb_rv;
    logic [DW-1:0]       r_exc_q;
    logic                r_exc_rv;

    logic [AW-1:0] r_addr;
    logic [DW-1:0] r_raw;
    logic [CW-1:0] r_cnt;
    logic          r_pend;
    logic [AW-1:0] r_pidx;
    logic [DW-1:0] r_max;
    logic [AW-1:0] r_best;
    logic          r_touch;
    logic [DW-1:0] r_ea;
    logic [DW-1:0] r_large;
    logic [DW-1:0] r_small;
    logic          r_up;
    logic [DW-1:0] r_range;
    logic [NW-1:0] r_num;
    logic [DW-1:0] r_base;
    logic [DW-1:0] r_off;
    logic [DW-1:0] r_pos;

    logic          r_out_v;
    logic          r_out_touched;
    logic [DW-1:0] r_out_pos;

    logic [CW-1:0] pads_eff;
    logic          smp_acc;
    logic          smp_in_range;
    logic [AW-1:0] smp_addr;
    logic          amb_we;
    logic          exc_we;
    logic [AW-1:0] exc_ra;
    logic [DW-1:0] amb_rd;
    logic [DW-1:0] exc_rd;
    logic [DW-1:0] excess;
    logic [AW-1:0] nbr_after;
    logic [AW-1:0] nbr_before;
    logic [DW-1:0] half;
    logic [PW-1:0] base_prod;
    logic          out_load;
    logic          frame_end;

    tsp_pkg::t_div_req div_req;
    tsp_pkg::t_div_rsp div_rsp;

    tsp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        if (r_num_pads < tsp_pkg::PADCNT_W'(2)) begin
            pads_eff = CW'(2);
        end else if (int'(r_num_pads) > MAX_PADS) begin
            pads_eff = CW'(MAX_PADS);
        end else begin
            pads_eff = CW'(r_num_pads);
        end
    end

    assign i_sample.ready = (r_state == ST_IDLE);
    assign i_cfg.ready    = 1'b1;
    assign smp_acc        = i_sample.valid && i_sample.ready;
    assign smp_in_range   = int'(i_sample.pad_index) < MAX_PADS;
    assign smp_addr       = AW'(i_sample.pad_index);
    assign amb_we         = smp_acc && smp_in_range && (i_sample.cmd == tsp_pkg::CMD_CALIBRATE);
    assign exc_we         = (r_state == ST_EXC);

    assign amb_rd = r_amb_rv ? r_amb_q : '0;
    assign exc_rd = r_exc_rv ? r_exc_q : '0;
    assign excess = (r_raw > amb_rd) ? (r_raw - amb_rd) : '0;
    assign frame_end = (CW'(r_addr) + CW'(1)) == pads_eff;

    assign nbr_after  = ((CW'(r_best) + CW'(1)) == pads_eff) ? '0 : r_best + 1'b1;
    assign nbr_before = (r_best == '0) ? AW'(pads_eff - CW'(1)) : r_best - 1'b1;
    assign half       = r_range >> 1;
    assign base_prod  = PW'(r_best) * PW'(r_range);

    always_comb begin
        priority if (r_state == ST_SCAN) begin
            exc_ra = AW'(r_cnt);
        end else if (r_state == ST_NBR_A) begin
            exc_ra = nbr_after;
        end else begin
            exc_ra = nbr_before;
        end
    end

    always_comb begin
        div_req.start    = (r_state == ST_NBR_C) || (r_state == ST_DIV_S);
        div_req.dividend = (r_state == ST_NBR_C) ? NW'(tsp_pkg::FULL_RANGE) : r_num;
        div_req.divisor  = (r_state == ST_NBR_C) ? DW'(pads_eff) : r_large;
    end

    assign out_load = (r_state == ST_DONE) && (!r_out_v || o_result.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (smp_acc && smp_in_range && (i_sample.cmd == tsp_pkg::CMD_MEASURE)) begin
                    n_state = ST_EXC;
                end
            end
            ST_EXC:   n_state = frame_end ? ST_SCAN : ST_IDLE;
            ST_SCAN:  n_state = (r_cnt < pads_eff) ? ST_SCAN : ST_NBR_A;
            ST_NBR_A: n_state = ST_NBR_B;
            ST_NBR_B: n_state = ST_NBR_C;
            ST_NBR_C: n_state = ST_DIV_R;
            ST_DIV_R: begin
                if (div_rsp.done) begin
                    n_state = ((r_best == '0) && (pads_eff > CW'(2))) ? ST_DONE : ST_MUL;
                end
            end
            ST_MUL:   n_state = (r_large == '0) ? ST_POS : ST_DIV_S;
            ST_DIV_S: n_state = ST_DIV_O;
            ST_DIV_O: n_state = div_rsp.done ? ST_POS : ST_DIV_O;
            ST_POS:   n_state = ST_DONE;
            ST_DONE:  n_state = out_load ? ST_IDLE : ST_DONE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_num_pads  <= tsp_pkg::RESET_NUM_PADS;
            r_threshold <= tsp_pkg::RESET_THRESHOLD;
            r_amb_vld   <= '0;
            r_exc_vld   <= '0;
            r_out_v     <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                if (i_cfg.index == tsp_pkg::CFG_NUM_PADS) begin
                    r_num_pads <= i_cfg.data[tsp_pkg::PADCNT_W-1:0];
                end else if (i_cfg.index == tsp_pkg::CFG_THRESHOLD) begin
                    r_threshold <= i_cfg.data;
                end
            end
            if (amb_we) begin
                r_amb_vld[smp_addr] <= 1'b1;
            end
            if (exc_we) begin
                r_exc_vld[r_addr] <= 1'b1;
            end
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (o_result.ready) begin
                r_out_v <= 1'b0;
            end
            if (r_state == ST_SCAN && r_cnt < pads_eff) begin
                r_pend <= 1'b1;
            end else begin
                r_pend <= 1'b0;
            end
        end
    end

    // memories: one write and one registered read per cycle each
    always_ff @(posedge i_clk) begin
        if (amb_we) begin
            r_amb_mem[smp_addr] <= i_sample.raw_value;
        end
        r_amb_q  <= r_amb_mem[smp_addr];
        r_amb_rv <= r_amb_vld[smp_addr];
    end

    always_ff @(posedge i_clk) begin
        if (exc_we) begin
            r_exc_mem[r_addr] <= excess;
        end
        r_exc_q  <= r_exc_mem[exc_ra];
        r_exc_rv <= r_exc_vld[exc_ra];
    end

    always_ff @(posedge i_clk) begin
        if (smp_acc) begin
            r_addr <= smp_addr;
            r_raw  <= i_sample.raw_value;
        end
        unique case (r_state)
            ST_EXC: begin
                r_cnt   <= '0;
                r_touch <= 1'b0;
                r_max   <= '0;
                r_best  <= '0;
            end
            ST_SCAN: begin
                if (r_pend) begin
                    if (exc_rd > r_threshold) begin
                        r_touch <= 1'b1;
                    end
                    if ((r_pidx == '0) || (exc_rd > r_max)) begin
                        r_max  <= exc_rd;
                        r_best <= r_pidx;
                    end
                end
                if (r_cnt < pads_eff) begin
                    r_pidx <= AW'(r_cnt);
                    r_cnt  <= r_cnt + 1'b1;
                end
            end
            ST_NBR_B: r_ea <= exc_rd;
            ST_NBR_C: begin
                if (r_ea > exc_rd) begin
                    r_large <= r_ea;
                    r_small <= exc_rd;
                    r_up    <= 1'b1;
                end else begin
                    r_large <= exc_rd;
                    r_small <= r_ea;
                    r_up    <= 1'b0;
                end
            end
            ST_DIV_R: begin
                if (div_rsp.done) begin
                    r_range <= div_rsp.quotient[DW-1:0] + 1'b1;
                    r_pos   <= '0;
                end
            end
            ST_MUL: begin
                r_num  <= NW'(r_large - r_small) * NW'(tsp_pkg::RANGE_EXT);
                r_base <= base_prod[DW-1:0];
                r_off  <= '0;
            end
            ST_DIV_O: begin
                if (div_rsp.done) begin
                    r_off <= (div_rsp.quotient > NW'(half)) ? half
                                                            : div_rsp.quotient[DW-1:0];
                end
            end
            ST_POS: r_pos <= r_up ? (r_base + r_off) : (r_base - r_off);
            default: begin
            end
        endcase
        if (out_load) begin
            r_out_touched <= r_touch;
            r_out_pos     <= r_touch ? r_pos : '0;
        end
    end

    assign o_result.valid    = r_out_v;
    assign o_result.touched  = r_out_touched;
    assign o_result.position = r_out_pos;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench of touch_slider_position_core against a slider position predictor.
module tb;

    localparam int unsigned PADS        = 16;
    localparam int unsigned POS_FULL    = 32'h10000;
    localparam int unsigned RATIO_SCALE = 32'hBD0 * 2;
    localparam int unsigned SETTLE_CYC  = 100;
    localparam int unsigned QUIET_LIMIT = 5000;
    localparam int unsigned N_PHASES    = 10;
    localparam int unsigned PHASE_ITEMS = 70;
    localparam logic [tsp_pkg::PADCNT_W-1:0]  NUM_PADS_INIT = 5'd10;
    localparam logic [tsp_pkg::DATA_W-1:0]    THRESH_INIT   = 16'd50;
    localparam logic [tsp_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO  = 8'd2;
    localparam logic [tsp_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI  = 8'd255;

    typedef struct {
        logic [tsp_pkg::CMD_W-1:0]  cmd;
        logic [tsp_pkg::IDX_W-1:0]  pad;
        logic [tsp_pkg::DATA_W-1:0] raw;
    } t_sample;

    typedef struct {
        logic                       touched;
        logic [tsp_pkg::DATA_W-1:0] position;
    } t_slider_res;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tsp_sample_if s_if ();
    tsp_cfg_if    c_if ();
    tsp_result_if r_if ();

    touch_slider_position_core #(.MAX_PADS(PADS)) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (s_if),
        .i_cfg    (c_if),
        .o_result (r_if)
    );

    t_sample                      sample_q[$];
    t_slider_res                  slider_q[$];
    t_sample                      next_req;
    t_slider_res                  want;
    logic [tsp_pkg::DATA_W-1:0]   ambient_m[PADS];
    logic [tsp_pkg::DATA_W-1:0]   excess_m[PADS];
    logic [tsp_pkg::DATA_W-1:0]   gen_ambient[PADS];
    logic [tsp_pkg::PADCNT_W-1:0] num_pads_m;
    logic [tsp_pkg::DATA_W-1:0]   threshold_m;
    int unsigned                  n_queued = 0;
    int unsigned                  n_taken = 0;
    int unsigned                  n_err = 0;
    int unsigned                  quiet_cyc = 0;
    int unsigned                  send_idle_pct = 0;
    int unsigned                  recv_stall_pct = 0;

    logic [tsp_pkg::DATA_W-1:0] num_pads_tab[N_PHASES] = '{16'd2, 16'd16, 16'd0, 16'd31,
                                                          16'hFFE5, 16'd1, 16'd3, 16'd17,
                                                          16'd8, 16'd10};
    logic [tsp_pkg::DATA_W-1:0] thresh_tab[N_PHASES]   = '{16'd0, 16'd65535, 16'd1000,
                                                          16'd200, 16'd30000, 16'd100,
                                                          16'd50, 16'd1, 16'd500, 16'd65534};

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned eff_pads(logic [tsp_pkg::PADCNT_W-1:0] pc);
        if (pc < 2)
            return 2;
        if (pc > PADS)
            return PADS;
        return 32'(pc);
    endfunction

    function automatic int unsigned ratio_offset(int unsigned big, int unsigned other,
                                                 int unsigned half);
        int unsigned rel;
        if (big == 0)
            return 0;
        rel = ((big - other) * RATIO_SCALE) / big;
        return (rel > half) ? half : rel;
    endfunction

    function automatic logic [tsp_pkg::DATA_W-1:0] calc_position(int unsigned n);
        int unsigned span, half, best, prev, next, e_prev, e_next, i;
        logic [31:0] pos;
        span = POS_FULL / n + 1;
        half = span / 2;
        best = 0;
        for (i = 1; i < n; i++)
            if (excess_m[i] > excess_m[best])
                best = i;
        prev = (best + n - 1) % n;
        next = (best + 1) % n;
        // strongest pad at the start of a real ring pins to zero
        if (best == 0 && prev > next)
            return '0;
        e_next = 32'(excess_m[next]);
        e_prev = 32'(excess_m[prev]);
        if (e_next > e_prev)
            pos = best * span + ratio_offset(e_next, e_prev, half);
        else
            pos = best * span - ratio_offset(e_prev, e_next, half);
        return pos[tsp_pkg::DATA_W-1:0];
    endfunction

    task automatic take_sample(input t_sample s);
        int unsigned n, i;
        t_slider_res res;
        if (s.cmd == tsp_pkg::CMD_CALIBRATE) begin
            ambient_m[s.pad] = s.raw;
            return;
        end
        excess_m[s.pad] = (s.raw > ambient_m[s.pad]) ? s.raw - ambient_m[s.pad] : '0;
        n = eff_pads(num_pads_m);
        if (s.pad != n - 1)
            return;
        res.touched = 1'b0;
        for (i = 0; i < n; i++)
            if (excess_m[i] > threshold_m)
                res.touched = 1'b1;
        res.position = res.touched ? calc_position(n) : '0;
        slider_q.push_back(res);
    endtask

    // predictor: follows accepted config writes and sample requests
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            num_pads_m  = NUM_PADS_INIT;
            threshold_m = THRESH_INIT;
            foreach (ambient_m[i]) begin
                ambient_m[i] = '0;
                excess_m[i]  = '0;
            end
        end else begin
            if (c_if.valid && c_if.ready) begin
                if (c_if.index == tsp_pkg::CFG_NUM_PADS)
                    num_pads_m = c_if.data[tsp_pkg::PADCNT_W-1:0];
                else if (c_if.index == tsp_pkg::CFG_THRESHOLD)
                    threshold_m = c_if.data;
            end
            if (s_if.valid && s_if.ready) begin
                take_sample('{cmd: s_if.cmd, pad: s_if.pad_index, raw: s_if.raw_value});
                n_taken++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_if.valid     <= 1'b0;
            s_if.cmd       <= tsp_pkg::CMD_MEASURE;
            s_if.pad_index <= '0;
            s_if.raw_value <= '0;
        end else if (!s_if.valid || s_if.ready) begin
            if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_req = sample_q.pop_front();
                s_if.valid     <= 1'b1;
                s_if.cmd       <= next_req.cmd;
                s_if.pad_index <= next_req.pad;
                s_if.raw_value <= next_req.raw;
            end else begin
                s_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            r_if.ready <= 1'b0;
        else
            r_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && r_if.valid && r_if.ready) begin
            if (slider_q.size() == 0) begin
                $display("%0t: result with none expected, touched %0d position %0d",
                         $time, r_if.touched, r_if.position);
                n_err++;
            end else begin
                want = slider_q.pop_front();
                if (r_if.touched !== want.touched) begin
                    $display("%0t: touched mismatch, expected %0d, actual %0d",
                             $time, want.touched, r_if.touched);
                    n_err++;
                end
                if (r_if.position !== want.position) begin
                    $display("%0t: position mismatch, expected %0d, actual %0d",
                             $time, want.position, r_if.position);
                    n_err++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_if.valid && s_if.ready) || (r_if.valid && r_if.ready)
                || (c_if.valid && c_if.ready)) begin
            quiet_cyc <= 0;
        end else if (quiet_cyc == QUIET_LIMIT) begin
            $display("%0t: no request moved for %0d cycles", $time, QUIET_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cyc <= quiet_cyc + 1;
        end
    end

    task automatic queue_req(logic [tsp_pkg::CMD_W-1:0] cmd, int unsigned pad,
                             int unsigned raw);
        t_sample s;
        s.cmd = cmd;
        s.pad = pad[tsp_pkg::IDX_W-1:0];
        s.raw = raw[tsp_pkg::DATA_W-1:0];
        if (cmd == tsp_pkg::CMD_CALIBRATE)
            gen_ambient[s.pad] = s.raw;
        sample_q.push_back(s);
        n_queued++;
    endtask

    // one frame of measurements shaped as a touch around a random peak pad
    task automatic queue_frame(int unsigned n);
        int unsigned peak, amp, shape, i, d, ex, raw;
        peak = $urandom_range(n - 1);
        shape = $urandom_range(9);
        amp = (shape < 4) ? $urandom_range(600) : $urandom_range(65535);
        for (i = 0; i < n; i++) begin
            if (i != n - 1 && $urandom_range(11) == 0)
                continue;
            d = (i > peak) ? i - peak : peak - i;
            if (n - d < d)
                d = n - d;
            if (shape == 8)
                ex = (d <= 1) ? amp : 0;
            else if (shape == 7)
                ex = (d == 0) ? amp : (d == 1) ? amp / 2 : 0;
            else
                ex = (amp >> (d * $urandom_range(1, 4))) + ((d != 0) ? $urandom_range(15) : 0);
            if (shape == 9)
                raw = $urandom_range(65535);
            else if ($urandom_range(9) == 0)
                raw = $urandom_range(32'(gen_ambient[i]));
            else
                raw = 32'(gen_ambient[i]) + ex;
            if (raw > 65535)
                raw = 65535;
            queue_req(tsp_pkg::CMD_MEASURE, i, raw);
        end
    endtask

    task automatic run_random(int unsigned n, int unsigned count);
        int unsigned first, pick, i;
        first = n_queued;
        for (i = 0; i < PADS; i++)
            queue_req(tsp_pkg::CMD_CALIBRATE, i,
                      ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(2000));
        while (n_queued - first < count) begin
            pick = $urandom_range(99);
            if (pick < 80)
                queue_frame(n);
            else if (pick < 90)
                queue_req(tsp_pkg::CMD_CALIBRATE, $urandom_range(PADS - 1),
                          $urandom_range(2500));
            else
                queue_req(($urandom_range(1) == 1) ? tsp_pkg::CMD_CALIBRATE
                                                   : tsp_pkg::CMD_MEASURE,
                          $urandom_range(PADS - 1), $urandom_range(65535));
        end
    endtask

    task automatic wait_idle();
        while (n_taken != n_queued || slider_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [tsp_pkg::CFG_IDX_W-1:0] idx,
                             logic [tsp_pkg::DATA_W-1:0] val);
        @(posedge i_clk);
        c_if.valid <= 1'b1;
        c_if.index <= idx;
        c_if.data  <= val;
        @(posedge i_clk);
        while (!c_if.ready)
            @(posedge i_clk);
        c_if.valid <= 1'b0;
    endtask

    initial begin
        int unsigned ph;
        i_rst_n        <= 1'b0;
        c_if.valid     <= 1'b0;
        c_if.index     <= tsp_pkg::CFG_NUM_PADS;
        c_if.data      <= '0;
        foreach (gen_ambient[i])
            gen_ambient[i] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration: 10 pads, threshold 50
        queue_req(tsp_pkg::CMD_MEASURE, 7, 123);        // ambient reads zero after reset
        queue_req(tsp_pkg::CMD_CALIBRATE, 2, 65535);
        queue_req(tsp_pkg::CMD_CALIBRATE, 9, 100);      // calibrate of last pad, no result
        queue_req(tsp_pkg::CMD_MEASURE, 2, 40000);      // below ambient, floored
        queue_req(tsp_pkg::CMD_MEASURE, 12, 65535);     // outside frame
        queue_req(tsp_pkg::CMD_MEASURE, 15, 65535);
        queue_req(tsp_pkg::CMD_MEASURE, 9, 100);        // both neighbors zero
        queue_req(tsp_pkg::CMD_MEASURE, 7, 50);         // equal to threshold
        queue_req(tsp_pkg::CMD_MEASURE, 9, 150);        // not touched
        queue_req(tsp_pkg::CMD_MEASURE, 0, 5000);
        queue_req(tsp_pkg::CMD_MEASURE, 1, 3000);
        queue_req(tsp_pkg::CMD_MEASURE, 9, 100);        // peak on pad zero
        queue_req(tsp_pkg::CMD_MEASURE, 0, 0);
        queue_req(tsp_pkg::CMD_MEASURE, 4, 65535);
        queue_req(tsp_pkg::CMD_MEASURE, 5, 65535);      // tie, first max wins, clamped offset
        queue_req(tsp_pkg::CMD_MEASURE, 9, 100);
        queue_req(tsp_pkg::CMD_MEASURE, 4, 1000);
        queue_req(tsp_pkg::CMD_MEASURE, 5, 400);
        queue_req(tsp_pkg::CMD_MEASURE, 3, 700);        // lower neighbor stronger
        queue_req(tsp_pkg::CMD_MEASURE, 1, 0);
        queue_req(tsp_pkg::CMD_MEASURE, 9, 100);
        queue_req(tsp_pkg::CMD_MEASURE, 0, 200);
        queue_req(tsp_pkg::CMD_MEASURE, 9, 65535);      // peak on last pad, wraps to pad zero
        wait_idle();

        for (ph = 0; ph < N_PHASES; ph++) begin
            write_reg(tsp_pkg::CFG_NUM_PADS, num_pads_tab[ph]);
            write_reg(tsp_pkg::CFG_THRESHOLD, thresh_tab[ph]);
            if (ph % 3 == 1)
                write_reg((ph == 4) ? CFG_SPARE_HI : CFG_SPARE_LO,
                          tsp_pkg::DATA_W'($urandom_range(65535)));
            case (ph % 4)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 45;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 45;
                end
                default: begin
                    send_idle_pct = 27;
                    recv_stall_pct = 27;
                end
            endcase
            run_random(eff_pads(num_pads_tab[ph][tsp_pkg::PADCNT_W-1:0]), PHASE_ITEMS + PADS);
            wait_idle();
        end

        if (n_err == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

@@ sim.f @@
src/tsp_pkg.sv
src/tsp_sample_if.sv
src/tsp_result_if.sv
src/tsp_cfg_if.sv
src/tsp_div.sv
src/touch_slider_position_core.sv
tb/tb.sv
